>>> rtl/bbm_pkg.sv
package bbm_pkg;

  // matrix geometry and field widths
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int MAX_RADIUS = 15;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int SAMPLE_W   = 16;
  localparam int RAD_W      = 4;
  localparam int SIZE_W     = 7;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // accumulator and divider sizing: at most 31x31 cells of 16 bits
  localparam int ACC_W     = 26;
  localparam int MAG_W     = ACC_W - 1;
  localparam int CNT_W     = 10;
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_DRAIN,
    S_DIV_INIT,
    S_DIV,
    S_OUT
  } bbm_state_t;

  typedef struct packed {
    logic wr_en;
    logic capture;
    logic setup;
    logic read;
    logic div_start;
    logic div_step;
    logic load_out;
  } bbm_cmd_t;

  typedef struct packed {
    logic last_cell;
    logic div_done;
    logic out_free;
  } bbm_stat_t;

endpackage

>>> rtl/bbm_in_if.sv
interface bbm_in_if import bbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, func, row, col, sample, input ready);
  modport sink   (input valid, func, row, col, sample, output ready);
endinterface

>>> rtl/bbm_out_if.sv
interface bbm_out_if import bbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] mean;
  logic [ROW_W-1:0]    out_row;
  logic [COL_W-1:0]    out_col;

  modport source (output valid, mean, out_row, out_col, input ready);
  modport sink   (input valid, mean, out_row, out_col, output ready);
endinterface

>>> rtl/bbm_ram.sv
module bbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bbm_ctrl.sv
module bbm_ctrl import bbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_func,
  output logic      in_ready,
  input  bbm_stat_t stat,
  output bbm_cmd_t  cmd
);

  bbm_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_READ) begin
            cmd.capture = 1'b1;
            state_nxt   = S_SETUP;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read = 1'b1;
        if (stat.last_cell) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bbm_dpath.sv
module bbm_dpath import bbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [ROW_W-1:0]      in_row,
  input  logic [COL_W-1:0]      in_col,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  bbm_cmd_t              cmd,
  output bbm_stat_t             stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_mean,
  output logic [ROW_W-1:0]      out_row,
  output logic [COL_W-1:0]      out_col
);

  logic [RAD_W-1:0]  radius_r;
  logic [SIZE_W-1:0] rows_r, cols_r;
  logic [ROW_W-1:0]  row_r, r0_r, r1_r, a_r;
  logic [COL_W-1:0]  col_r, c0_r, c1_r, b_r;
  logic              rd_pend_r;
  logic [ACC_W-1:0]  acc_r;
  logic [MAG_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r, div_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [SAMPLE_W-1:0] mean_r;
  logic [ROW_W-1:0]  orow_r;
  logic [COL_W-1:0]  ocol_r;
  logic [SAMPLE_W-1:0] rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(1);
      rows_r   <= SIZE_W'(MAX_ROWS);
      cols_r   <= SIZE_W'(MAX_COLS);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RADIUS: radius_r <= cfg_wdata[RAD_W-1:0];
        CFG_ROWS:   rows_r   <= cfg_wdata[SIZE_W-1:0];
        CFG_COLS:   cols_r   <= cfg_wdata[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  // clipped window bounds
  logic [RAD_W-1:0]  rad;
  logic [SIZE_W-1:0] rlast_w, clast_w;
  logic [ROW_W-1:0]  rlast, cr, r0, r1;
  logic [COL_W-1:0]  clast, cc, c0, c1;
  logic [SIZE_W-1:0] rhi, chi;

  always_comb begin
    rad = (radius_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_r;
    if (rows_r == '0)                        rlast_w = '0;
    else if (rows_r > SIZE_W'(MAX_ROWS))     rlast_w = SIZE_W'(MAX_ROWS - 1);
    else                                     rlast_w = rows_r - SIZE_W'(1);
    if (cols_r == '0)                        clast_w = '0;
    else if (cols_r > SIZE_W'(MAX_COLS))     clast_w = SIZE_W'(MAX_COLS - 1);
    else                                     clast_w = cols_r - SIZE_W'(1);
    rlast = rlast_w[ROW_W-1:0];
    clast = clast_w[COL_W-1:0];
    cr = (row_r > rlast) ? rlast : row_r;
    cc = (col_r > clast) ? clast : col_r;
    r0 = (cr >= ROW_W'(rad)) ? cr - ROW_W'(rad) : '0;
    c0 = (cc >= COL_W'(rad)) ? cc - COL_W'(rad) : '0;
    rhi = SIZE_W'(cr) + SIZE_W'(rad);
    chi = SIZE_W'(cc) + SIZE_W'(rad);
    r1 = (rhi > SIZE_W'(rlast)) ? rlast : rhi[ROW_W-1:0];
    c1 = (chi > SIZE_W'(clast)) ? clast : chi[COL_W-1:0];
  end

  // position capture and window scan
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (cmd.setup) begin
      r0_r <= r0;
      r1_r <= r1;
      c0_r <= c0;
      c1_r <= c1;
      a_r  <= r0;
      b_r  <= c0;
    end else if (cmd.read) begin
      if (b_r == c1_r) begin
        b_r <= c0_r;
        a_r <= a_r + ROW_W'(1);
      end else begin
        b_r <= b_r + COL_W'(1);
      end
    end
  end

  assign stat.last_cell = (a_r == r1_r) && (b_r == c1_r);

  // sample store
  bbm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr ({in_row, in_col}),
    .wdata (in_sample),
    .re    (cmd.read),
    .raddr ({a_r, b_r}),
    .rdata (rd_data)
  );

  // accumulate one read beat a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      acc_r <= '0;
    end else if (rd_pend_r) begin
      acc_r <= acc_r + ACC_W'(signed'(rd_data));
    end
  end

  // restoring divider on magnitudes, one quotient bit a cycle
  logic [ACC_W-1:0]  acc_neg;
  logic [SIZE_W-1:0] nrows, ncols;
  logic [CNT_W:0]    rem_sh, rem_sub;
  logic [MAG_W-1:0]  quo_sh;

  always_comb begin
    acc_neg = -acc_r;
    nrows   = SIZE_W'(r1_r - r0_r) + SIZE_W'(1);
    ncols   = SIZE_W'(c1_r - c0_r) + SIZE_W'(1);
    rem_sh  = {rem_r, quo_r[MAG_W-1]};
    quo_sh  = {quo_r[MAG_W-2:0], 1'b0};
    rem_sub = rem_sh - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r  <= acc_r[ACC_W-1];
      quo_r  <= acc_r[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_r[MAG_W-1:0];
      rem_r  <= '0;
      div_r  <= CNT_W'(nrows) * CNT_W'(ncols);
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + STEP_W'(1);
      if (rem_sh >= {1'b0, div_r}) begin
        rem_r <= rem_sub[CNT_W-1:0];
        quo_r <= {quo_sh[MAG_W-1:1], 1'b1};
      end else begin
        rem_r <= rem_sh[CNT_W-1:0];
        quo_r <= quo_sh;
      end
    end
  end

  assign stat.div_done = (step_r == STEP_W'(DIV_STEPS - 1));

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_r <= neg_r ? -quo_r[SAMPLE_W-1:0] : quo_r[SAMPLE_W-1:0];
      orow_r <= row_r;
      ocol_r <= col_r;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_mean      = mean_r;
  assign out_row       = orow_r;
  assign out_col       = ocol_r;

endmodule

>>> rtl/box_blur_matrix.sv
// box blur over a 64x64 matrix of signed 16-bit samples
// in_bus: func=0 writes sample at (row, col); func=1 asks for the mean of
//   the square window of half width radius around (row, col), clipped to
//   the rows and columns in use, truncated toward zero
// out_bus: one beat per read item with mean, out_row and out_col
// a write beat is stored while idle and the block stays idle; a read runs
//   a setup step, then sums one stored cell per cycle through the single
//   read port of the sample store, then a drain step, a divider load, the
//   bit-serial divider and an output load, and the block then returns to
//   idle to take the next item
// one item is in work at a time; in_bus.ready is high only while idle
// the result register frees in the cycle its beat is taken; while the
//   receiver stalls, a finished read waits and no new item is taken
// cfg_we writes register cfg_idx (0 radius, 1 rows in use, 2 columns in
//   use) from cfg_wdata; write only while the block is idle
// synchronous reset sets radius 1 and a 64x64 used area and empties the
//   result register; sample contents are undefined until written
module box_blur_matrix import bbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bbm_in_if.sink                in_bus,
  bbm_out_if.source             out_bus
);

  bbm_cmd_t  cmd;
  bbm_stat_t stat;

  // sequencer
  bbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_func  (in_bus.func),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, accumulator, divider and result register
  bbm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_row    (in_bus.row),
    .in_col    (in_bus.col),
    .in_sample (in_bus.sample),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_mean  (out_bus.mean),
    .out_row   (out_bus.out_row),
    .out_col   (out_bus.out_col)
  );

`ifndef SYNTHESIS
  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over a pending beat");

  // scanning and dividing never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.read && (cmd.div_step || cmd.div_start)))
    else $error("read and divide commands together");

  // a loaded result is offered in the next cycle
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_bus.valid)
    else $error("loaded result not offered");

  // no input beat taken while a read is in work
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.setup || cmd.read || cmd.div_step) |-> !in_bus.ready)
    else $error("input taken during a read");
`endif

endmodule
